FILE: src/dtcs_pkg.sv
// shared types and constants of the disk transfer chunk sequencer
`timescale 1ns / 1ps
package dtcs_pkg;

  localparam logic [7:0] CMD_READ  = 8'hde;
  localparam logic [7:0] CMD_WRITE = 8'he6;
  localparam int unsigned SECTOR_SHIFT = 9;

  localparam logic OP_START    = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic KIND_ISSUE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ARGUMENT   = 2'd1;
  localparam logic [1:0] ERR_FAIL       = 2'd2;
  localparam logic [1:0] ERR_FAIL_SENSE = 2'd3;

  localparam logic [1:0] CFG_SPT     = 2'd0;
  localparam logic [1:0] CFG_SPC     = 2'd1;
  localparam logic [1:0] CFG_SPU     = 2'd2;
  localparam logic [1:0] CFG_NORETRY = 2'd3;

  localparam int unsigned DIV_DW = 24;
  localparam int unsigned DIV_VW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CYL,
    ST_HEAD,
    ST_SECT
  } seq_state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_VW-1:0] rem;
  } div_rsp_t;

endpackage

FILE: src/dtcs_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dtcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtcs_pkg::div_req_t req_i,
  output dtcs_pkg::div_rsp_t rsp_o
);
  import dtcs_pkg::*;

  localparam int unsigned CW = $clog2(DIV_DW);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] quot_q, quot_d;
  logic [DIV_VW-1:0] dvs_q, dvs_d;
  logic [DIV_VW:0]   trial;
  logic              ge;

  assign trial = {rem_q, quot_q[DIV_DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (run_q) begin
      rem_d  = ge ? DIV_VW'(trial - {1'b0, dvs_q}) : trial[DIV_VW-1:0];
      quot_d = {quot_q[DIV_DW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: src/disk_transfer_chunk_sequencer.sv
// disk transfer chunk sequencer: request check, chunking and retry control
// an argument error or a finish goes to the output register when accepted; an
// ignored completion gives no output; a chunk issue takes three passes of the shared
// divider (cylinder and offset, head, sector in track); one item is worked at a time
// the input stalls while an issue is in progress or a held result blocks the output
// reset: async active low, idle with no request in flight, control registers at defaults
`timescale 1ns / 1ps
module disk_transfer_chunk_sequencer #(
  parameter int unsigned UNIT_COUNT  = 8,
  parameter int unsigned MAX_CHUNK   = 128,
  parameter int unsigned RETRY_LIMIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic        write_request_i,
  input  logic [3:0]  unit_number_i,
  input  logic [23:0] first_sector_i,
  input  logic [15:0] sector_total_i,
  input  logic [23:0] buffer_address_i,
  input  logic        chunk_failed_i,
  input  logic [15:0] sense_bytes_i,
  input  logic [7:0]  residual_sectors_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  device_command_o,
  output logic [2:0]  drive_select_o,
  output logic [15:0] cylinder_number_o,
  output logic [4:0]  head_number_o,
  output logic [7:0]  track_sector_o,
  output logic [7:0]  chunk_sectors_o,
  output logic [23:0] chunk_address_o,
  output logic [15:0] sectors_done_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] sense_value_o
);
  import dtcs_pkg::*;

  // configuration registers
  logic [7:0]  spt_q;
  logic [15:0] spc_q;
  logic [23:0] spu_q;
  logic        noretry_q;
  logic [7:0]  spt_eff;
  logic [15:0] spc_eff;

  // request state
  logic        busy_q;
  logic        is_write_q;
  logic [2:0]  drive_q;
  logic [23:0] nsec_q;
  logic [15:0] remain_q;
  logic [15:0] orig_q;
  logic [23:0] naddr_q;
  logic [7:0]  chunk_q;
  logic [4:0]  retry_q;
  logic        pick_q;
  logic [15:0] cyl_q;
  logic [4:0]  head_q;

  seq_state_e state_q, state_d;

  // output register
  logic        ov_q;
  logic        kind_q;
  logic [7:0]  cmd_q;
  logic [2:0]  dsel_q;
  logic [15:0] ocyl_q;
  logic [4:0]  ohead_q;
  logic [7:0]  otrk_q;
  logic [7:0]  ochunk_q;
  logic [23:0] oaddr_q;
  logic [15:0] odone_q;
  logic [1:0]  oerr_q;
  logic [15:0] osense_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_acc;
  logic        arg_err;
  logic [24:0] end_sector;
  logic [15:0] remain_ok;
  logic [23:0] nsec_ok;
  logic [23:0] naddr_ok;
  logic        retry_ok;
  logic [7:0]  resid;
  logic [15:0] left;
  logic [16:0] room;
  logic [15:0] pick_n;
  logic [7:0]  halved;
  logic        go_start, go_next, go_retry;
  logic        fin_acc;
  logic        ov_set;
  logic [23:0] div_ns;

  assign spt_eff = (spt_q == '0) ? 8'd1 : spt_q;
  assign spc_eff = (spc_q == '0) ? 16'd1 : spc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q     <= 8'd32;
      spc_q     <= 16'd256;
      spu_q     <= '0;
      noretry_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPT:     spt_q     <= cfg_data_i[7:0];
        CFG_SPC:     spc_q     <= cfg_data_i[15:0];
        CFG_SPU:     spu_q     <= cfg_data_i;
        CFG_NORETRY: noretry_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // a new item only in idle and only when the output slot is free this cycle
  assign in_stall_o = (state_q != ST_IDLE) || (ov_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // start checks
  assign end_sector = {1'b0, first_sector_i} + {9'd0, sector_total_i};
  assign arg_err = busy_q || ({28'd0, unit_number_i} >= 32'(UNIT_COUNT)) ||
                   (buffer_address_i[SECTOR_SHIFT-1:0] != '0) ||
                   (sector_total_i == '0) || (end_sector > {1'b0, spu_q});

  // completion arithmetic
  assign remain_ok = remain_q - {8'd0, chunk_q};
  assign nsec_ok   = nsec_q + {16'd0, chunk_q};
  assign naddr_ok  = naddr_q + 24'({chunk_q, {SECTOR_SHIFT{1'b0}}});
  assign retry_ok  = !noretry_q && (retry_q <= 5'(RETRY_LIMIT));
  assign resid     = (residual_sectors_i > chunk_q) ? chunk_q : residual_sectors_i;
  assign left      = remain_q - {8'd0, chunk_q} + {8'd0, resid};
  assign halved    = {1'b0, chunk_q[7:1]} | 8'd1;

  assign go_start = in_acc && (opcode_i == OP_START) && !arg_err;
  assign go_next  = in_acc && (opcode_i == OP_COMPLETE) && busy_q && !chunk_failed_i &&
                    (remain_ok != '0);
  assign go_retry = in_acc && (opcode_i == OP_COMPLETE) && busy_q && chunk_failed_i &&
                    retry_ok;

  // finished result: argument error, success or final failure
  assign fin_acc = in_acc && !go_start && !go_next && !go_retry &&
                   (opcode_i == OP_START || busy_q);
  assign ov_set  = fin_acc || (state_q == ST_SECT && div_rsp.done);

  // chunk clip: up to cylinder end, remaining count and chunk limit
  always_comb begin
    room   = {1'b0, spc_eff} - {1'b0, div_rsp.rem};
    pick_n = room[15:0];
    if (room > {1'b0, remain_q}) pick_n = remain_q;
    if (pick_n > 16'(MAX_CHUNK)) pick_n = 16'(MAX_CHUNK);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (go_start || go_next || go_retry) state_d = ST_CYL;
      ST_CYL:  if (div_rsp.done) state_d = ST_HEAD;
      ST_HEAD: if (div_rsp.done) state_d = ST_SECT;
      ST_SECT: if (div_rsp.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    if (go_start)     div_ns = first_sector_i;
    else if (go_next) div_ns = nsec_ok;
    else              div_ns = nsec_q;
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        div_req.start    = go_start || go_next || go_retry;
        div_req.dividend = div_ns;
        div_req.divisor  = spc_eff;
      end
      ST_CYL: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {8'd0, div_rsp.rem};
        div_req.divisor  = {8'd0, spt_eff};
      end
      ST_HEAD: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = nsec_q;
        div_req.divisor  = {8'd0, spt_eff};
      end
      default: ;
    endcase
  end

  dtcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      busy_q     <= 1'b0;
      is_write_q <= 1'b0;
      drive_q    <= '0;
      nsec_q     <= '0;
      remain_q   <= '0;
      orig_q     <= '0;
      naddr_q    <= '0;
      chunk_q    <= '0;
      retry_q    <= '0;
      pick_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_set || (ov_q && out_stall_i);
      if (in_acc) begin
        if (opcode_i == OP_START) begin
          if (!arg_err) begin
            busy_q     <= 1'b1;
            is_write_q <= write_request_i;
            drive_q    <= unit_number_i[2:0];
            nsec_q     <= first_sector_i;
            remain_q   <= sector_total_i;
            orig_q     <= sector_total_i;
            naddr_q    <= buffer_address_i;
            pick_q     <= 1'b1;
          end
        end else if (busy_q) begin
          if (!chunk_failed_i) begin
            remain_q <= remain_ok;
            nsec_q   <= nsec_ok;
            naddr_q  <= naddr_ok;
            pick_q   <= 1'b1;
            if (remain_ok == '0) begin
              busy_q <= 1'b0;
            end
          end else if (retry_ok) begin
            retry_q <= retry_q + 1'b1;
            chunk_q <= halved;
            pick_q  <= 1'b0;
          end else begin
            busy_q <= 1'b0;
          end
        end
      end
      if (state_q == ST_CYL && div_rsp.done && pick_q) begin
        chunk_q <= pick_n[7:0];
        retry_q <= '0;
      end
    end
  end

  // geometry and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CYL && div_rsp.done) cyl_q <= div_rsp.quot[15:0];
    if (state_q == ST_HEAD && div_rsp.done) head_q <= div_rsp.quot[4:0];
    if (state_q == ST_SECT && div_rsp.done) begin
      kind_q   <= KIND_ISSUE;
      cmd_q    <= is_write_q ? CMD_WRITE : CMD_READ;
      dsel_q   <= drive_q;
      ocyl_q   <= cyl_q;
      ohead_q  <= head_q;
      otrk_q   <= div_rsp.rem[7:0];
      ochunk_q <= chunk_q;
      oaddr_q  <= naddr_q;
      odone_q  <= '0;
      oerr_q   <= ERR_NONE;
      osense_q <= '0;
    end else if (fin_acc) begin
      kind_q   <= KIND_FINISH;
      cmd_q    <= '0;
      dsel_q   <= '0;
      ocyl_q   <= '0;
      ohead_q  <= '0;
      otrk_q   <= '0;
      ochunk_q <= '0;
      oaddr_q  <= '0;
      osense_q <= '0;
      if (opcode_i == OP_START) begin
        odone_q <= '0;
        oerr_q  <= ERR_ARGUMENT;
      end else if (!chunk_failed_i) begin
        odone_q <= orig_q;
        oerr_q  <= ERR_NONE;
      end else begin
        odone_q <= orig_q - left;
        if (sense_bytes_i != '0) begin
          oerr_q   <= ERR_FAIL_SENSE;
          osense_q <= sense_bytes_i;
        end else begin
          oerr_q <= ERR_FAIL;
        end
      end
    end
  end

  assign out_valid_o       = ov_q;
  assign result_kind_o     = kind_q;
  assign device_command_o  = cmd_q;
  assign drive_select_o    = dsel_q;
  assign cylinder_number_o = ocyl_q;
  assign head_number_o     = ohead_q;
  assign track_sector_o    = otrk_q;
  assign chunk_sectors_o   = ochunk_q;
  assign chunk_address_o   = oaddr_q;
  assign sectors_done_o    = odone_q;
  assign error_code_o      = oerr_q;
  assign sense_value_o     = osense_q;

endmodule
